// ===== rtl/adgr_pkg.sv =====
// adgr_pkg: shared types and constants for the audio ducking gate
// no dependencies

package adgr_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_THRESHOLD  = 3'd1,
    CFG_DUCK_GAIN  = 3'd2,
    CFG_HOLD_TICKS = 3'd3,
    CFG_STEP_SIZE  = 3'd4
  } cfg_idx_t;

  // reset values, given in Q16 and rescaled where used
  localparam longint RST_FRAC_BITS  = 16;
  localparam longint RST_THRESHOLD  = 3277;
  localparam longint RST_DUCK_GAIN  = 16384;
  localparam longint RST_HOLD_TICKS = 17;
  localparam longint RST_STEP_SIZE  = 9830;

  typedef struct packed {
    logic enable;
    logic clear;
  } cfg_ctl_t;

endpackage

// ===== rtl/adgr_cfg_regs.sv =====
// adgr_cfg_regs: configuration register file of the ducking gate
// depends on adgr_pkg

module adgr_cfg_regs #(
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int HOLD_COUNT_BITS = 16,
  parameter int CFG_W           = 17
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [adgr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]                   cfg_data,
  output adgr_pkg::cfg_ctl_t                 ctl,
  output logic [LEVEL_FRAC_BITS:0]           threshold,
  output logic [LEVEL_FRAC_BITS:0]           duck_gain,
  output logic [HOLD_COUNT_BITS-1:0]         hold_ticks,
  output logic [LEVEL_FRAC_BITS:0]           step_size
);
  import adgr_pkg::*;

  localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
  localparam int HOLD_W  = HOLD_COUNT_BITS;

  localparam logic [LEVEL_W-1:0] THR_RST = (LEVEL_FRAC_BITS >= RST_FRAC_BITS) ?
    LEVEL_W'(RST_THRESHOLD << (LEVEL_FRAC_BITS - RST_FRAC_BITS)) :
    LEVEL_W'(RST_THRESHOLD >> (RST_FRAC_BITS - LEVEL_FRAC_BITS));
  localparam logic [LEVEL_W-1:0] DUCK_RST = (LEVEL_FRAC_BITS >= RST_FRAC_BITS) ?
    LEVEL_W'(RST_DUCK_GAIN << (LEVEL_FRAC_BITS - RST_FRAC_BITS)) :
    LEVEL_W'(RST_DUCK_GAIN >> (RST_FRAC_BITS - LEVEL_FRAC_BITS));
  localparam logic [LEVEL_W-1:0] STEP_RST = (LEVEL_FRAC_BITS >= RST_FRAC_BITS) ?
    LEVEL_W'(RST_STEP_SIZE << (LEVEL_FRAC_BITS - RST_FRAC_BITS)) :
    LEVEL_W'(RST_STEP_SIZE >> (RST_FRAC_BITS - LEVEL_FRAC_BITS));
  localparam logic [HOLD_W-1:0] HOLD_RST = HOLD_W'(RST_HOLD_TICKS);

  logic               enable_r, enable_nxt;
  logic               clear_nxt;
  logic [LEVEL_W-1:0] threshold_r, threshold_nxt;
  logic [LEVEL_W-1:0] duck_gain_r, duck_gain_nxt;
  logic [HOLD_W-1:0]  hold_ticks_r, hold_ticks_nxt;
  logic [LEVEL_W-1:0] step_size_r, step_size_nxt;

  always_comb begin
    enable_nxt     = enable_r;
    clear_nxt      = 1'b0;
    threshold_nxt  = threshold_r;
    duck_gain_nxt  = duck_gain_r;
    hold_ticks_nxt = hold_ticks_r;
    step_size_nxt  = step_size_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE: begin
          enable_nxt = cfg_data[0];
          clear_nxt  = ~cfg_data[0];
        end
        CFG_THRESHOLD:  threshold_nxt  = cfg_data[LEVEL_W-1:0];
        CFG_DUCK_GAIN:  duck_gain_nxt  = cfg_data[LEVEL_W-1:0];
        CFG_HOLD_TICKS: hold_ticks_nxt = cfg_data[HOLD_W-1:0];
        CFG_STEP_SIZE:  step_size_nxt  = cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b1;
      threshold_r  <= THR_RST;
      duck_gain_r  <= DUCK_RST;
      hold_ticks_r <= HOLD_RST;
      step_size_r  <= STEP_RST;
    end else begin
      enable_r     <= enable_nxt;
      threshold_r  <= threshold_nxt;
      duck_gain_r  <= duck_gain_nxt;
      hold_ticks_r <= hold_ticks_nxt;
      step_size_r  <= step_size_nxt;
    end
  end

  // clear acts in the same cycle as the write so the state is cleared at once
  assign ctl.enable = enable_r;
  assign ctl.clear  = clear_nxt;
  assign threshold  = threshold_r;
  assign duck_gain  = duck_gain_r;
  assign hold_ticks = hold_ticks_r;
  assign step_size  = step_size_r;

endmodule

// ===== rtl/adgr_core.sv =====
// adgr_core: gate with hold counter and linear gain slew, holds the gate state
// depends on adgr_pkg

module adgr_core #(
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int HOLD_COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  adgr_pkg::cfg_ctl_t         ctl,
  input  logic [LEVEL_FRAC_BITS:0]   threshold,
  input  logic [LEVEL_FRAC_BITS:0]   duck_gain,
  input  logic [HOLD_COUNT_BITS-1:0] hold_ticks,
  input  logic [LEVEL_FRAC_BITS:0]   step_size,
  input  logic                       fire,
  input  logic [LEVEL_FRAC_BITS:0]   mic_left,
  input  logic [LEVEL_FRAC_BITS:0]   mic_right,
  output logic [LEVEL_FRAC_BITS:0]   gain,
  output logic                       ducking,
  output logic                       gain_changed
);
  import adgr_pkg::*;

  localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
  localparam int HOLD_W  = HOLD_COUNT_BITS;
  localparam logic [LEVEL_W-1:0] UNITY    = LEVEL_W'(1) << LEVEL_FRAC_BITS;
  localparam logic [HOLD_W-1:0]  HOLD_MAX = '1;

  logic               duck_r, duck_nxt;
  logic               hold_r, hold_nxt;
  logic [HOLD_W-1:0]  cnt_r, cnt_nxt;
  logic [LEVEL_W-1:0] gain_r, gain_nxt;

  logic [LEVEL_W-1:0] level;
  logic [HOLD_W-1:0]  cnt_inc;
  logic               g_duck;
  logic               g_hold;
  logic [HOLD_W-1:0]  g_cnt;
  logic [LEVEL_W-1:0] target;
  logic [LEVEL_W-1:0] step;
  logic [LEVEL_W-1:0] diff;
  logic [LEVEL_W-1:0] slewed;

  assign level   = (mic_left > mic_right) ? mic_left : mic_right;
  assign cnt_inc = (cnt_r != HOLD_MAX) ? cnt_r + HOLD_W'(1) : cnt_r;

  // gate with hold
  always_comb begin
    g_duck = 1'b0;
    g_hold = 1'b0;
    g_cnt  = '0;
    if (level >= threshold) begin
      g_duck = 1'b1;
    end else if (!duck_r) begin
      g_duck = 1'b0;
    end else if (!hold_r) begin
      g_duck = 1'b1;
      g_hold = 1'b1;
    end else if (cnt_inc >= hold_ticks) begin
      g_duck = 1'b0;
    end else begin
      g_duck = 1'b1;
      g_hold = 1'b1;
      g_cnt  = cnt_inc;
    end
  end

  // linear slew toward the target
  always_comb begin
    target = g_duck ? ((duck_gain > UNITY) ? UNITY : duck_gain) : UNITY;
    step   = (step_size == '0) ? LEVEL_W'(1) : step_size;
    diff   = '0;
    slewed = gain_r;
    if (gain_r < target) begin
      diff   = target - gain_r;
      slewed = (diff <= step) ? target : gain_r + step;
    end else if (gain_r > target) begin
      diff   = gain_r - target;
      slewed = (diff <= step) ? target : gain_r - step;
    end
  end

  always_comb begin
    duck_nxt = duck_r;
    hold_nxt = hold_r;
    cnt_nxt  = cnt_r;
    gain_nxt = gain_r;
    if (ctl.clear || (fire && !ctl.enable)) begin
      duck_nxt = 1'b0;
      hold_nxt = 1'b0;
      cnt_nxt  = '0;
      gain_nxt = UNITY;
    end else if (fire) begin
      duck_nxt = g_duck;
      hold_nxt = g_hold;
      cnt_nxt  = g_cnt;
      gain_nxt = slewed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duck_r <= 1'b0;
      hold_r <= 1'b0;
      cnt_r  <= '0;
      gain_r <= UNITY;
    end else begin
      duck_r <= duck_nxt;
      hold_r <= hold_nxt;
      cnt_r  <= cnt_nxt;
      gain_r <= gain_nxt;
    end
  end

  always_comb begin
    if (!ctl.enable) begin
      gain         = UNITY;
      ducking      = 1'b0;
      gain_changed = (gain_r != UNITY);
    end else begin
      gain         = slewed;
      ducking      = g_duck;
      gain_changed = (slewed != gain_r);
    end
  end

`ifndef SYNTHESIS
  a_gain_le_unity: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= UNITY) else $error("gain above unity");
  a_hold_needs_duck: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r |-> duck_r) else $error("hold running while not ducking");
  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_r |-> cnt_r == '0) else $error("quiet count set without hold");
  a_disabled_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !ctl.enable |=> gain_r == UNITY && !duck_r)
    else $error("disabled item left state");
  a_slew_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ctl.enable && !ctl.clear |=>
      ((gain_r >= $past(gain_r)) ? (gain_r - $past(gain_r)) : ($past(gain_r) - gain_r))
        <= (($past(step_size) == '0) ? LEVEL_W'(1) : $past(step_size)))
    else $error("gain moved more than one step");
`endif

endmodule

// ===== rtl/audio_ducking_gate_ramp_unit.sv =====
// audio_ducking_gate_ramp_unit: top level of the audio ducking gate with hold and slew
// depends on adgr_pkg, adgr_cfg_regs, adgr_core
//
// usage
//   in_*  : one item per poll tick, left and right mic peak levels, unsigned
//           with LEVEL_FRAC_BITS fraction bits (unity = 1 << LEVEL_FRAC_BITS)
//   out_* : one result item per input item, in order: gain, ducking flag and
//           a flag that is high when the gain moved on this tick
//   cfg_* : register writes (enable, threshold, duck_gain, hold_ticks, step_size
//           by index 0..4), always ready; the user must write only while the block is
//           idle (not enforced); writing enable = 0 clears the gate state at once
// timing
//   an item is registered on acceptance, processed by one stage of compare,
//   hold counter and slew logic, and registered again at the output, where the
//   result is valid; one item per cycle sustained while out_ready stays high
// reset
//   synchronous, active low; registers return to their defaults, gain to unity
// stall
//   when out_ready is low the output holds; the input register still takes one
//   more item if it is empty, after which in_ready drops until the output is taken

module audio_ducking_gate_ramp_unit #(
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int HOLD_COUNT_BITS = 16,
  localparam int CFG_W = (LEVEL_FRAC_BITS + 1 > HOLD_COUNT_BITS) ?
                         LEVEL_FRAC_BITS + 1 : HOLD_COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [LEVEL_FRAC_BITS:0]           in_mic_left,
  input  logic [LEVEL_FRAC_BITS:0]           in_mic_right,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [LEVEL_FRAC_BITS:0]           out_gain,
  output logic                               out_ducking,
  output logic                               out_gain_changed,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [adgr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]                   cfg_data
);
  import adgr_pkg::*;

  localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;

  cfg_ctl_t                     ctl;
  logic [LEVEL_W-1:0]           threshold;
  logic [LEVEL_W-1:0]           duck_gain;
  logic [HOLD_COUNT_BITS-1:0]   hold_ticks;
  logic [LEVEL_W-1:0]           step_size;

  logic               s1_valid_r, s1_valid_nxt;
  logic [LEVEL_W-1:0] s1_left_r;
  logic [LEVEL_W-1:0] s1_right_r;
  logic               o_valid_r, o_valid_nxt;
  logic [LEVEL_W-1:0] o_gain_r;
  logic               o_duck_r;
  logic               o_chg_r;

  logic               advance;
  logic               fire;
  logic [LEVEL_W-1:0] c_gain;
  logic               c_duck;
  logic               c_chg;

  assign cfg_ready = 1'b1;

  adgr_cfg_regs #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
    .HOLD_COUNT_BITS (HOLD_COUNT_BITS),
    .CFG_W           (CFG_W)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctl        (ctl),
    .threshold  (threshold),
    .duck_gain  (duck_gain),
    .hold_ticks (hold_ticks),
    .step_size  (step_size)
  );

  // output register free or being emptied
  assign advance  = !o_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  adgr_core #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
    .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .threshold    (threshold),
    .duck_gain    (duck_gain),
    .hold_ticks   (hold_ticks),
    .step_size    (step_size),
    .fire         (fire),
    .mic_left     (s1_left_r),
    .mic_right    (s1_right_r),
    .gain         (c_gain),
    .ducking      (c_duck),
    .gain_changed (c_chg)
  );

  always_comb begin
    s1_valid_nxt = in_ready ? in_valid : s1_valid_r;
    o_valid_nxt  = advance ? s1_valid_r : o_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_left_r  <= in_mic_left;
      s1_right_r <= in_mic_right;
    end
    if (fire) begin
      o_gain_r <= c_gain;
      o_duck_r <= c_duck;
      o_chg_r  <= c_chg;
    end
  end

  assign out_valid        = o_valid_r;
  assign out_gain         = o_gain_r;
  assign out_ducking      = o_duck_r;
  assign out_gain_changed = o_chg_r;

endmodule

// ===== dv/adgr_tb_pkg.sv =====
`timescale 1ns / 1ps
// adgr_tb_pkg: gain predictor and result scoreboard for the audio ducking gate testbench
// depends on adgr_pkg for the register index codes and reset values

package adgr_tb_pkg;
  import adgr_pkg::*;

  localparam int LVL_W = 17;
  localparam int HOLD_W = 16;
  localparam logic [LVL_W-1:0] UNITY = 17'h10000;
  localparam logic [HOLD_W-1:0] HOLD_SAT = '1;

  typedef struct packed {
    logic [LVL_W-1:0] gain;
    logic             ducking;
    logic             changed;
  } duck_result_t;

  class duck_scoreboard;
    logic              en;
    logic [LVL_W-1:0]  thr;
    logic [LVL_W-1:0]  dgain;
    logic [HOLD_W-1:0] hold;
    logic [LVL_W-1:0]  step;
    logic              gate_on;
    logic              hold_on;
    logic [HOLD_W-1:0] quiet;
    logic [LVL_W-1:0]  gain_now;
    duck_result_t      expected_q[$];
    int                errors;
    int                accepted;
    int                checked;
    int                duck_seen;
    int                moved_seen;

    function new();
      en = 1'b1;
      thr = LVL_W'(RST_THRESHOLD);
      dgain = LVL_W'(RST_DUCK_GAIN);
      hold = HOLD_W'(RST_HOLD_TICKS);
      step = LVL_W'(RST_STEP_SIZE);
      clear_gate();
    endfunction

    function void clear_gate();
      gate_on = 1'b0;
      hold_on = 1'b0;
      quiet = '0;
      gain_now = UNITY;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [LVL_W-1:0] data);
      case (idx)
        CFG_ENABLE: begin
          en = data[0];
          if (!en) clear_gate();
        end
        CFG_THRESHOLD:  thr = data;
        CFG_DUCK_GAIN:  dgain = data;
        CFG_HOLD_TICKS: hold = data[HOLD_W-1:0];
        CFG_STEP_SIZE:  step = data;
        default: ;
      endcase
    endfunction

    function void note_input(logic [LVL_W-1:0] mic_l, logic [LVL_W-1:0] mic_r);
      logic [LVL_W-1:0] lvl;
      logic [LVL_W-1:0] tgt;
      logic [LVL_W-1:0] stp;
      logic [LVL_W-1:0] prev;
      duck_result_t     res;
      accepted++;
      prev = gain_now;
      if (!en) begin
        clear_gate();
        res.gain = UNITY;
        res.ducking = 1'b0;
        res.changed = (prev != UNITY);
      end else begin
        lvl = (mic_l > mic_r) ? mic_l : mic_r;
        if (lvl >= thr) begin
          gate_on = 1'b1;
          hold_on = 1'b0;
          quiet = '0;
        end else if (!gate_on) begin
          hold_on = 1'b0;
          quiet = '0;
        end else if (!hold_on) begin
          hold_on = 1'b1;
          quiet = '0;
        end else begin
          if (quiet != HOLD_SAT) quiet = quiet + 1'b1;
          if (quiet >= hold) begin
            gate_on = 1'b0;
            hold_on = 1'b0;
            quiet = '0;
          end
        end
        tgt = gate_on ? ((dgain > UNITY) ? UNITY : dgain) : UNITY;
        stp = (step == '0) ? LVL_W'(1) : step;
        // linear slew toward the target
        if (prev < tgt) gain_now = (tgt - prev <= stp) ? tgt : prev + stp;
        else if (prev > tgt) gain_now = (prev - tgt <= stp) ? tgt : prev - stp;
        res.gain = gain_now;
        res.ducking = gate_on;
        res.changed = (gain_now != prev);
      end
      expected_q.push_back(res);
    endfunction

    function void flag(string what, duck_result_t want, duck_result_t got);
      errors++;
      if (errors <= 10)
        $display("%s: exp gain=%0d duck=%0b chg=%0b, got gain=%0d duck=%0b chg=%0b",
                 what, want.gain, want.ducking, want.changed,
                 got.gain, got.ducking, got.changed);
    endfunction

    function void check_result(logic [LVL_W-1:0] gain, logic ducking, logic changed);
      duck_result_t got;
      duck_result_t want;
      got.gain = gain;
      got.ducking = ducking;
      got.changed = changed;
      checked++;
      if (ducking) duck_seen++;
      if (changed) moved_seen++;
      if (expected_q.size() == 0) begin
        flag("result with no item pending", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (want.gain !== got.gain || want.ducking !== got.ducking ||
            want.changed !== got.changed)
          flag("result mismatch", want, got);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void final_check();
      if (expected_q.size() != 0) begin
        errors += expected_q.size();
        $display("%0d results never arrived", expected_q.size());
      end
    endfunction
  endclass

endpackage

// ===== dv/audio_ducking_gate_ramp_unit_tb.sv =====
`timescale 1ns / 1ps
// audio_ducking_gate_ramp_unit_tb: drives mic levels and register writes into the ducking gate,
// predicts gain, ducking and change flag per item and checks every result item in order
// depends on adgr_pkg, adgr_tb_pkg and audio_ducking_gate_ramp_unit

module audio_ducking_gate_ramp_unit_tb;
  import adgr_pkg::*;
  import adgr_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 13;
  localparam int PHASE_ITEMS = 118;
  localparam int MAX_LVL = 131071;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} stall_mode_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [LVL_W-1:0] in_mic_left = '0;
  logic [LVL_W-1:0] in_mic_right = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [LVL_W-1:0] out_gain;
  logic             out_ducking;
  logic             out_gain_changed;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ENABLE;
  logic [LVL_W-1:0] cfg_data = '0;

  duck_scoreboard   sb = new();
  int               cfg_writes;
  int               burst_left;
  int               idle_cycles;
  int               rx_cycle;
  stall_mode_t      rx_mode = RX_OPEN;
  logic [LVL_W-1:0] thr_now;
  logic [HOLD_W-1:0] hold_now;

  audio_ducking_gate_ramp_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mic_left(in_mic_left),
    .in_mic_right(in_mic_right),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_gain(out_gain),
    .out_ducking(out_ducking),
    .out_gain_changed(out_gain_changed),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic send_level(input logic [LVL_W-1:0] mic_l, input logic [LVL_W-1:0] mic_r);
    int gap;
    in_valid <= 1'b1;
    in_mic_left <= mic_l;
    in_mic_right <= mic_r;
    do @(posedge clk); while (!in_ready);
    sb.note_input(mic_l, mic_r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [LVL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_writes++;
  endtask

  // registers change only once every pending result is back
  task automatic set_config(input logic en, input logic [LVL_W-1:0] thr,
                            input logic [LVL_W-1:0] dg, input logic [HOLD_W-1:0] hold,
                            input logic [LVL_W-1:0] step);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    put_reg(CFG_THRESHOLD, thr);
    put_reg(CFG_DUCK_GAIN, dg);
    put_reg(CFG_HOLD_TICKS, {1'b0, hold});
    put_reg(CFG_STEP_SIZE, step);
    put_reg(CFG_ENABLE, {{(LVL_W-1){1'b0}}, en});
    cfg_valid <= 1'b0;
    thr_now = thr;
    hold_now = hold;
  endtask

  // loud and quiet runs around the threshold, with some raw noise mixed in
  task automatic run_phase(input int n);
    int               sent;
    int               run_len;
    int               quiet_max;
    int               k;
    bit               loud;
    logic [LVL_W-1:0] lvl;
    logic [LVL_W-1:0] other;
    sent = 0;
    quiet_max = (hold_now > 36) ? 40 : int'(hold_now) + 4;
    while (sent < n) begin
      loud = (thr_now == '0) || ($urandom_range(0, 2) == 0);
      run_len = loud ? $urandom_range(1, 6) : $urandom_range(1, quiet_max);
      for (k = 0; k < run_len && sent < n; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_level(LVL_W'($urandom_range(0, MAX_LVL)), LVL_W'($urandom_range(0, MAX_LVL)));
        end else begin
          if (loud)
            lvl = ($urandom_range(0, 7) == 0) ? thr_now
                                              : LVL_W'($urandom_range(thr_now, MAX_LVL));
          else
            lvl = ($urandom_range(0, 7) == 0) ? thr_now - 1'b1
                                              : LVL_W'($urandom_range(0, thr_now - 1));
          other = LVL_W'($urandom_range(0, lvl));
          if ($urandom_range(0, 1)) send_level(lvl, other);
          else send_level(other, lvl);
        end
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready)
      sb.check_result(out_gain, out_ducking, out_gain_changed);
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = stall_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:    out_ready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: out_ready <= (rx_cycle % 4 != 3);
      default:     out_ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int p;
    thr_now = LVL_W'(RST_THRESHOLD);
    hold_now = HOLD_W'(RST_HOLD_TICKS);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: silence, threshold edges, full scale on each side
    send_level(17'd0, 17'd0);
    send_level(17'd3276, 17'd3276);
    send_level(17'd3277, 17'd0);
    send_level(17'd0, 17'd3277);
    send_level(17'd131071, 17'd65536);
    send_level(17'd0, 17'd131071);
    send_level(17'd0, 17'd0);

    // zero hold, zero step, duck gain above unity
    set_config(1'b1, 17'd65536, 17'd131071, 16'd0, 17'd0);
    send_level(17'd65536, 17'd0);
    send_level(17'd0, 17'd0);
    send_level(17'd0, 17'd0);
    send_level(17'd65535, 17'd65535);

    // zero threshold with zero duck gain and a full step
    set_config(1'b1, 17'd0, 17'd0, 16'd0, 17'd65536);
    send_level(17'd0, 17'd0);
    send_level(17'd0, 17'd0);
    send_level(17'd77777, 17'd0);

    // disabled
    set_config(1'b0, 17'd0, 17'd0, 16'd0, 17'd65536);
    send_level(17'd0, 17'd0);
    send_level(17'd131071, 17'd131071);

    // top threshold, largest step, hold of one
    set_config(1'b1, 17'd131071, 17'd0, 16'd1, 17'd131071);
    send_level(17'd131071, 17'd0);
    send_level(17'd0, 17'd0);
    send_level(17'd0, 17'd0);
    send_level(17'd0, 17'd0);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(1'b1, 17'd3277, 17'd16384, 16'd17, 17'd9830);
        1: set_config(1'b1, 17'd0, 17'd0, 16'd0, 17'd65536);
        2: set_config(1'b1, 17'd65536, 17'd65536, 16'd65535, 17'd1);
        3: set_config(1'b0, 17'd30000, 17'd8000, 16'd2, 17'd500);
        4: set_config(1'b1, 17'd131071, 17'd131071, 16'd1, 17'd0);
        5: set_config(1'b1, 17'd20000, 17'd0, 16'd3, 17'd131071);
        default: set_config($urandom_range(0, 7) != 0,
                            LVL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_LVL)
                                                               : $urandom_range(1000, 40000)),
                            LVL_W'($urandom_range(0, 70000)),
                            HOLD_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                                : $urandom_range(0, 8)),
                            LVL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_LVL)
                                                               : $urandom_range(1, 4000)));
      endcase
      run_phase(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.final_check();
    $display("sent %0d items across %0d register settings with %0d register writes",
             sb.accepted, PHASES + 5, cfg_writes);
    $display("checked %0d results: %0d while ducking, %0d with the gain moving",
             sb.checked, sb.duck_seen, sb.moved_seen);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
